### hdl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, register codes, cofactor wiring table and result saturation
// for the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEM_W        = 32;
	localparam int N_ELEM        = 9;
	localparam int TOL_W         = 31;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_AW        = 3;
	localparam int CFG_DW        = 32;
	localparam int Q_W           = ELEM_W + 1;
	localparam int DIV_LAT       = Q_W + 3;

	localparam logic REG_TOL = 1'b0;
	localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(1);

	// element indices (a, b, c, d) of cofactor a*b - c*d, row-major order
	localparam logic [3:0] COF_SEL [0:N_ELEM-1][0:3] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

	function automatic logic [ELEM_W-1:0] sat_q(input logic neg, input logic hi_nz,
			input logic [Q_W-1:0] mag);
		logic [ELEM_W-1:0] r;
		if (!neg) begin
			r = (hi_nz || mag[Q_W-1] || mag[ELEM_W-1]) ? {1'b0, {(ELEM_W-1){1'b1}}}
				: mag[ELEM_W-1:0];
		end else begin
			r = (hi_nz || mag[Q_W-1] || (mag[ELEM_W-1] && (|mag[ELEM_W-2:0])))
				? {1'b1, {(ELEM_W-1){1'b0}}} : (~mag[ELEM_W-1:0] + 1'b1);
		end
		return r;
	endfunction

endpackage

### hdl/mi3_dly.sv
// ----------------------------------------------------------------------------
// mi3_dly
// Fixed-length delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module mi3_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] dly_q [0:N-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign q = dly_q[N-1];

endmodule

### hdl/mi3_cof.sv
// ----------------------------------------------------------------------------
// mi3_cof
// One cofactor lane: a*b - c*d exactly, returned as magnitude and sign.
// ----------------------------------------------------------------------------
module mi3_cof (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [mi3_pkg::ELEM_W-1:0] a,
	input  logic signed [mi3_pkg::ELEM_W-1:0] b,
	input  logic signed [mi3_pkg::ELEM_W-1:0] c,
	input  logic signed [mi3_pkg::ELEM_W-1:0] d,
	output logic [2*mi3_pkg::ELEM_W-1:0]      mag,
	output logic                              neg
);
	import mi3_pkg::*;

	localparam int PW = 2 * ELEM_W;

	logic signed [PW-1:0] pab_s1, pcd_s1;
	logic signed [PW:0]   diff_s2;
	logic [PW-1:0]        mag_s3;
	logic                 neg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pab_s1  <= a * b;
			pcd_s1  <= c * d;
			diff_s2 <= (PW+1)'(pab_s1) - (PW+1)'(pcd_s1);
			neg_s3  <= diff_s2[PW];
			mag_s3  <= diff_s2[PW] ? PW'(-diff_s2) : PW'(diff_s2);
		end
	end

	assign mag = mag_s3;
	assign neg = neg_s3;

endmodule

### hdl/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Determinant merge: row-0 expansion over the cofactor lanes, magnitude,
// rounding, singular test and saturated determinant.
// ----------------------------------------------------------------------------
module mi3_det #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [mi3_pkg::TOL_W-1:0]           tol,
	input  logic [2:0][mi3_pkg::ELEM_W-1:0]     row,
	input  logic [2:0][2*mi3_pkg::ELEM_W-1:0]   cmag,
	input  logic [2:0]                          cneg,
	output logic [3*mi3_pkg::ELEM_W-1:0]        dmag,
	output logic                                dneg,
	output logic                                sing,
	output logic [mi3_pkg::ELEM_W-1:0]          dval
);
	import mi3_pkg::*;

	localparam int CMW = 2 * ELEM_W;
	localparam int DMW = 3 * ELEM_W;
	localparam int DQW = DMW + 1 - 2 * FRAC_BITS;
	localparam logic [DMW:0] HALF = ((DMW+1)'(1) << (2 * FRAC_BITS)) >> 1;

	logic [ELEM_W-1:0] ma_s1 [0:2], ma_s2 [0:2], ma_s3 [0:2];
	logic [2:0]        mn_s1, mn_s2, mn_s3;
	logic [CMW-1:0]    plo_s4 [0:2], phi_s4 [0:2];
	logic [2:0]        tn_s4;
	logic [DMW:0]      term_s5 [0:2];
	logic [DMW:0]      sum_s6;
	logic [DMW-1:0]    dmag_s7;
	logic              dneg_s7;
	logic [DQW-1:0]    dq_s8;
	logic              dz_s8, dneg_s8;
	logic              sing_s9;
	logic [ELEM_W-1:0] dval_s9;
	logic [DMW:0]      tx [0:2];
	logic [DMW:0]      rnd;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tx[k] = ((DMW+1)'(phi_s4[k]) << ELEM_W) + (DMW+1)'(plo_s4[k]);
		end
		rnd = {1'b0, dmag_s7} + HALF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mn_s1[k]   <= row[k][ELEM_W-1];
				ma_s1[k]   <= row[k][ELEM_W-1] ? (~row[k] + 1'b1) : row[k];
				ma_s2[k]   <= ma_s1[k];
				ma_s3[k]   <= ma_s2[k];
				plo_s4[k]  <= ma_s3[k] * cmag[k][ELEM_W-1:0];
				phi_s4[k]  <= ma_s3[k] * cmag[k][CMW-1:ELEM_W];
				term_s5[k] <= tn_s4[k] ? (~tx[k] + 1'b1) : tx[k];
			end
			mn_s2   <= mn_s1;
			mn_s3   <= mn_s2;
			tn_s4   <= mn_s3 ^ cneg;
			sum_s6  <= term_s5[0] + term_s5[1] + term_s5[2];
			dneg_s7 <= sum_s6[DMW];
			dmag_s7 <= sum_s6[DMW] ? DMW'(~sum_s6 + 1'b1) : sum_s6[DMW-1:0];
			dq_s8   <= rnd[DMW:2*FRAC_BITS];
			dz_s8   <= (dmag_s7 == '0);
			dneg_s8 <= dneg_s7;
			sing_s9 <= (dq_s8 <= DQW'(tol)) || dz_s8;
			dval_s9 <= sat_q(dneg_s8, |dq_s8[DQW-1:Q_W], dq_s8[Q_W-1:0]);
		end
	end

	assign dmag = dmag_s7;
	assign dneg = dneg_s7;
	assign sing = sing_s9;
	assign dval = dval_s9;

endmodule

### hdl/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// One inverse lane: rounded, saturated adjugate entry over determinant by a
// pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mi3_div #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [2*mi3_pkg::ELEM_W-1:0]   cmag,
	input  logic                           cneg,
	input  logic [3*mi3_pkg::ELEM_W-1:0]   dmag,
	input  logic                           dneg,
	output logic [mi3_pkg::ELEM_W-1:0]     q
);
	import mi3_pkg::*;

	localparam int CMW = 2 * ELEM_W;
	localparam int DMW = 3 * ELEM_W;
	localparam int DNW = DMW + 1;
	localparam int NW  = ((CMW + 1 + 2 * FRAC_BITS) > DMW ? (CMW + 1 + 2 * FRAC_BITS) : DMW) + 1;
	localparam int RW  = (NW > DNW + Q_W) ? NW : DNW + Q_W;

	logic [RW-1:0]     rem_s1;
	logic [DNW-1:0]    dn_s1;
	logic              neg_s1;
	logic [RW-1:0]     rem_p [0:Q_W-1];
	logic [DNW-1:0]    dn_p  [0:Q_W-1];
	logic [Q_W-1:0]    q_p   [0:Q_W];
	logic              ovf_p [0:Q_W];
	logic              neg_p [0:Q_W];
	logic [ELEM_W-1:0] res_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1   <= (RW'(cmag) << (2 * FRAC_BITS + 1)) + RW'(dmag);
			dn_s1    <= {dmag, 1'b0};
			neg_s1   <= cneg ^ dneg;
			rem_p[0] <= rem_s1;
			dn_p[0]  <= dn_s1;
			q_p[0]   <= '0;
			ovf_p[0] <= (rem_s1 >= (RW'(dn_s1) << Q_W));
			neg_p[0] <= neg_s1;
			res_q    <= sat_q(neg_p[Q_W], ovf_p[Q_W], q_p[Q_W]);
		end
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_bit
		localparam int B = Q_W - j;
		logic [RW-1:0] t;
		logic          ge;
		assign t  = RW'(dn_p[j-1]) << B;
		assign ge = (rem_p[j-1] >= t);

		always_ff @(posedge clk) begin
			if (en) begin
				q_p[j]   <= q_p[j-1] | (ge ? (Q_W'(1) << B) : '0);
				ovf_p[j] <= ovf_p[j-1];
				neg_p[j] <= neg_p[j-1];
			end
		end

		if (j < Q_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_p[j] <= ge ? (rem_p[j-1] - t) : rem_p[j-1];
					dn_p[j]  <= dn_p[j-1];
				end
			end
		end
	end

	assign q = res_q;

endmodule

### hdl/matrix3x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Streaming 3x3 matrix inverse by the adjugate method in signed Q format.
//
// Input stream: one 3x3 matrix per transfer, nine signed elements m00..m22.
// Output stream: one transfer per matrix with the nine inverse elements, the
// rounded determinant and, in tuser, a singular flag. A matrix whose rounded
// determinant magnitude is at or below zero_tolerance yields the identity.
// zero_tolerance sits at APB address 0 (reset value 1); write it while idle.
// Path from input transfer to result valid: nine cofactor lanes, the
// determinant merge, nine divider lanes (one quotient bit per stage, 33
// bits plus set-up and saturation), then the output register.
// Throughput: one matrix per cycle. When the receiver stalls, the result is
// held in the output register and the pipeline keeps accepting input until
// its last stage holds a matrix; then s_tready falls until the result moves.
// Reset clears all valid flags and loads the tolerance reset value.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       psel,
	input  logic                                       penable,
	input  logic                                       pwrite,
	input  logic [mi3_pkg::CFG_AW-1:0]                 paddr,
	input  logic [mi3_pkg::CFG_DW-1:0]                 pwdata,
	output logic [mi3_pkg::CFG_DW-1:0]                 prdata,
	output logic                                       pready,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22
	input  logic [mi3_pkg::N_ELEM*mi3_pkg::ELEM_W-1:0] s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, det_value
	output logic [(mi3_pkg::N_ELEM+1)*mi3_pkg::ELEM_W-1:0] m_tdata,
	// singular
	output logic [0:0]                                 m_tuser
);
	import mi3_pkg::*;

	localparam int CMW   = 2 * ELEM_W;
	localparam int DMW   = 3 * ELEM_W;
	localparam int P     = 7 + DIV_LAT;
	localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

	logic [TOL_W-1:0]  tol_q;
	logic [P-1:0]      vld_q;
	logic              en;
	logic              out_v_q;
	logic              out_ld;
	logic [ELEM_W-1:0] mat [0:N_ELEM-1];
	logic [CMW-1:0]    cmag [0:N_ELEM-1];
	logic              cneg [0:N_ELEM-1];
	logic [CMW-1:0]    cmag_d [0:N_ELEM-1];
	logic              cneg_d [0:N_ELEM-1];
	logic [DMW-1:0]    dmag;
	logic              dneg;
	logic              sing, sing_d;
	logic [ELEM_W-1:0] dval, dval_d;
	logic [ELEM_W-1:0] inv [0:N_ELEM-1];
	logic [(N_ELEM+1)*ELEM_W-1:0] data_q;
	logic              user_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TOL) ? CFG_DW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOL) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	assign en       = !vld_q[P-1] || !out_v_q || m_tready;
	assign s_tready = en;
	assign out_ld   = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[P-2:0], s_tvalid};
			end
			if (out_ld) begin
				out_v_q <= vld_q[P-1];
			end
		end
	end

	for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
		localparam int R = k / 3;
		localparam int C = k % 3;
		assign mat[k] = s_tdata[k*ELEM_W +: ELEM_W];

		mi3_cof u_cof (
			.clk (clk),
			.en  (en),
			.a   (mat[COF_SEL[k][0]]),
			.b   (mat[COF_SEL[k][1]]),
			.c   (mat[COF_SEL[k][2]]),
			.d   (mat[COF_SEL[k][3]]),
			.mag (cmag[k]),
			.neg (cneg[k])
		);

		mi3_dly #(.W(CMW + 1), .N(4)) u_cdly (
			.clk (clk),
			.en  (en),
			.d   ({cneg[k], cmag[k]}),
			.q   ({cneg_d[k], cmag_d[k]})
		);

		mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk  (clk),
			.en   (en),
			.cmag (cmag_d[C*3+R]),
			.cneg (cneg_d[C*3+R]),
			.dmag (dmag),
			.dneg (dneg),
			.q    (inv[k])
		);
	end

	mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
		.clk  (clk),
		.en   (en),
		.tol  (tol_q),
		.row  ({mat[2], mat[1], mat[0]}),
		.cmag ({cmag[2], cmag[1], cmag[0]}),
		.cneg ({cneg[2], cneg[1], cneg[0]}),
		.dmag (dmag),
		.dneg (dneg),
		.sing (sing),
		.dval (dval)
	);

	mi3_dly #(.W(ELEM_W + 1), .N(DIV_LAT - 2)) u_sdly (
		.clk (clk),
		.en  (en),
		.d   ({sing, dval}),
		.q   ({sing_d, dval_d})
	);

	always_ff @(posedge clk) begin
		if (out_ld && vld_q[P-1]) begin
			for (int k = 0; k < N_ELEM; k++) begin
				if (sing_d) begin
					data_q[k*ELEM_W +: ELEM_W] <= (k % 4 == 0) ? ONE : '0;
				end else begin
					data_q[k*ELEM_W +: ELEM_W] <= inv[k];
				end
			end
			data_q[N_ELEM*ELEM_W +: ELEM_W] <= dval_d;
			user_q <= sing_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

`ifndef SYNTHESIS
	a_sing_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[ELEM_W-1:0] == ONE
			&& m_tdata[2*ELEM_W-1:ELEM_W] == '0
			&& m_tdata[5*ELEM_W-1:4*ELEM_W] == ONE
			&& m_tdata[9*ELEM_W-1:8*ELEM_W] == ONE)
		else $error("singular result is not the identity");
	a_det_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[10*ELEM_W-1:9*ELEM_W] != '0)
		else $error("regular result with zero determinant");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && vld_q[P-1])
		else $error("input stalled without a held result");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[P-1] && out_ld |=> m_tvalid)
		else $error("finished matrix not moved to output");
`endif

endmodule
